>>> rtl/core/obb_sat_pkg.sv
// Shared types, constants and tables for the oriented box overlap unit.
package obb_sat_pkg;

    localparam int CTR_W        = 24;
    localparam int LEN_W        = 23;
    localparam int TURN_W       = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int IDX_W        = $clog2(CORDIC_STEPS);
    localparam int CORD_W       = 34;
    localparam int ARC_W        = 30;
    localparam int OPD_W        = 32;
    localparam int ACC_W        = 64;
    localparam int VTX_W        = 26;
    localparam int IN_W         = 224;
    localparam int OUT_W        = 72;

    localparam logic signed [CORD_W-1:0] CORDIC_GAIN = CORD_W'(652032874);
    localparam logic [LEN_W-1:0]         DEPTH_MAX   = {LEN_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRIG,
        ST_CORNER,
        ST_PROJ,
        ST_AXIS,
        ST_ORIENT,
        ST_PUSH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                    clr;
        logic                    neg;
        logic signed [OPD_W-1:0] a;
        logic signed [OPD_W-1:0] b;
    } mac_op_t;

    typedef struct packed {
        logic signed [OPD_W-1:0] x;
        logic signed [OPD_W-1:0] y;
    } vec_t;

    function automatic logic [ARC_W-1:0] arc(input logic [IDX_W-1:0] i);
        logic [ARC_W-1:0] v;
        unique case (i)
            5'd0:    v = 30'h20000000;
            5'd1:    v = 30'h12E4051E;
            5'd2:    v = 30'h09FB385B;
            5'd3:    v = 30'h051111D4;
            5'd4:    v = 30'h028B0D43;
            5'd5:    v = 30'h0145D7E1;
            5'd6:    v = 30'h00A2F61E;
            5'd7:    v = 30'h00517C55;
            5'd8:    v = 30'h0028BE53;
            5'd9:    v = 30'h00145F2F;
            5'd10:   v = 30'h000A2F98;
            5'd11:   v = 30'h000517CC;
            5'd12:   v = 30'h00028BE6;
            5'd13:   v = 30'h000145F3;
            5'd14:   v = 30'h0000A2FA;
            5'd15:   v = 30'h0000517D;
            5'd16:   v = 30'h000028BE;
            5'd17:   v = 30'h0000145F;
            5'd18:   v = 30'h00000A30;
            5'd19:   v = 30'h00000518;
            5'd20:   v = 30'h0000028C;
            5'd21:   v = 30'h00000146;
            5'd22:   v = 30'h000000A3;
            5'd23:   v = 30'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic vec_t edge_normal(input logic [1:0] m,
                                         input logic signed [OPD_W-1:0] c,
                                         input logic signed [OPD_W-1:0] s);
        vec_t n;
        unique case (m)
            2'd0:    begin n.x = -c; n.y = -s; end
            2'd1:    begin n.x = s;  n.y = -c; end
            2'd2:    begin n.x = c;  n.y = s;  end
            default: begin n.x = -s; n.y = c;  end
        endcase
        return n;
    endfunction

endpackage

>>> rtl/core/obb_sat_cordic.sv
// Iterative shift-add rotator giving cosine and sine of a binary angle.
module obb_sat_cordic
    import obb_sat_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [TURN_W-1:0]       turn,
    output logic                    done,
    output logic signed [OPD_W-1:0] cos_val,
    output logic signed [OPD_W-1:0] sin_val
);

    logic signed [CORD_W-1:0] x_reg, y_reg, z_reg;
    logic signed [CORD_W-1:0] x_next, y_next, z_next;
    logic [IDX_W-1:0]         idx_reg;
    logic [1:0]               q_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic [TURN_W-1:0]        t_adj;
    logic [1:0]               q_new;
    logic [TURN_W-1:0]        r_new;
    logic signed [CORD_W-1:0] sh_x, sh_y, arc_ext;
    logic signed [OPD_W-1:0]  xs, ys;

    assign t_adj   = turn + TURN_W'(16'h2000);
    assign q_new   = t_adj[TURN_W-1 -: 2];
    assign r_new   = {turn[TURN_W-1 -: 2] - q_new, turn[TURN_W-3:0]};
    assign sh_x    = x_reg >>> idx_reg;
    assign sh_y    = y_reg >>> idx_reg;
    assign arc_ext = CORD_W'(arc(idx_reg));

    always_comb
    begin
        if (!z_reg[CORD_W-1])
        begin
            x_next = x_reg - sh_y;
            y_next = y_reg + sh_x;
            z_next = z_reg - arc_ext;
        end
        else
        begin
            x_next = x_reg + sh_y;
            y_next = y_reg - sh_x;
            z_next = z_reg + arc_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (idx_reg == IDX_W'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= CORDIC_GAIN;
            y_reg <= '0;
            z_reg <= {{2{r_new[TURN_W-1]}}, r_new, 16'b0};
            q_reg <= q_new;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign xs   = x_reg[OPD_W-1:0];
    assign ys   = y_reg[OPD_W-1:0];
    assign done = done_reg;

    always_comb
    begin
        unique case (q_reg)
            2'd0:    begin cos_val = xs;  sin_val = ys;  end
            2'd1:    begin cos_val = -ys; sin_val = xs;  end
            2'd2:    begin cos_val = -xs; sin_val = -ys; end
            default: begin cos_val = ys;  sin_val = -xs; end
        endcase
    end

endmodule

>>> rtl/core/obb_sat_mac.sv
// Shared signed multiply-accumulate unit.
module obb_sat_mac
    import obb_sat_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  mac_op_t                 op,
    output logic signed [ACC_W-1:0] acc
);

    logic signed [ACC_W-1:0] prod;
    logic signed [ACC_W-1:0] base;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    assign prod     = op.a * op.b;
    assign base     = op.clr ? '0 : acc_reg;
    assign acc_next = op.neg ? base - prod : base + prod;

    always_ff @(posedge clk)
    begin
        if (en)
            acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

>>> rtl/core/obb_separating_axis_collision_unit.sv
// Top level: sequencer and registers of the oriented box overlap unit.
// Work per item: two 24-step rotations, 16 corner values and 64 projections of two
// products each on one MAC (fewer when an axis separates the boxes), then push-out.
// The block is not ready for a new item while it works on one.
// A finished result waits in the output register while the next item is taken.
// Reset (rst_n low, asynchronous) clears the sequencer and the output valid.
module obb_separating_axis_collision_unit
    import obb_sat_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // a_center_x, a_center_y, a_width, a_height, a_turn,
    // b_center_x, b_center_y, b_width, b_height, b_turn, zero pad
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // overlap_found, overlap_depth, moved_center_x, moved_center_y
    output logic [OUT_W-1:0] m_axis_tdata
);

    state_t state_reg, state_next;
    logic [5:0] step_reg, step_next;
    logic [1:0] phase_reg, phase_next;

    logic signed [CTR_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [LEN_W-1:0]        aw_reg, ah_reg, bw_reg, bh_reg;
    logic [TURN_W-1:0]       at_reg, bt_reg;
    logic signed [OPD_W-1:0] a_cos_reg, a_sin_reg, b_cos_reg, b_sin_reg;
    logic signed [VTX_W-1:0] vx_reg [8];
    logic signed [VTX_W-1:0] vy_reg [8];
    logic signed [ACC_W-1:0] loa_reg, hia_reg, lob_reg, hib_reg, best_reg;
    logic [2:0]              best_idx_reg;
    logic                    flip_reg;
    logic                    found_reg;
    logic [LEN_W-1:0]        depth_reg;
    logic signed [CTR_W-1:0] mx_reg, my_reg;
    logic                    out_valid_reg;
    logic [OUT_W-1:0]        out_data_reg;

    logic                    accept;
    logic                    cordic_start, cordic_done;
    logic signed [OPD_W-1:0] cordic_cos, cordic_sin;
    logic                    mac_en;
    mac_op_t                 mac_op;
    logic signed [ACC_W-1:0] acc;
    logic                    out_free;

    logic                    rect;
    logic [1:0]              corner;
    logic signed [OPD_W-1:0] len_w, len_h, rc, rs;
    logic                    sx_neg, sy_neg;
    vec_t                    proj_n, best_n, push_n;
    logic [2:0]              vi;
    logic signed [ACC_W-1:0] h_min, l_max, d_val;
    logic                    separated;
    logic signed [ACC_W-1:0] rnd31, rnd30, vsum, msum;
    logic signed [CTR_W-1:0] cval, mclamp;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    obb_sat_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .turn    (step_reg[0] ? bt_reg : at_reg),
        .done    (cordic_done),
        .cos_val (cordic_cos),
        .sin_val (cordic_sin)
    );

    obb_sat_mac u_mac (
        .clk (clk),
        .en  (mac_en),
        .op  (mac_op),
        .acc (acc)
    );

    // operand selection
    assign rect   = step_reg[3];
    assign corner = step_reg[2:1];
    assign len_w  = OPD_W'(rect ? bw_reg : aw_reg);
    assign len_h  = OPD_W'(rect ? bh_reg : ah_reg);
    assign rc     = rect ? b_cos_reg : a_cos_reg;
    assign rs     = rect ? b_sin_reg : a_sin_reg;
    assign sx_neg = corner[1];
    assign sy_neg = (corner[1] == corner[0]);
    assign vi     = step_reg[2:0];
    assign proj_n = edge_normal(step_reg[4:3], step_reg[5] ? b_cos_reg : a_cos_reg,
                                step_reg[5] ? b_sin_reg : a_sin_reg);
    assign best_n = edge_normal(best_idx_reg[1:0], best_idx_reg[2] ? b_cos_reg : a_cos_reg,
                                best_idx_reg[2] ? b_sin_reg : a_sin_reg);
    assign push_n.x = flip_reg ? -best_n.x : best_n.x;
    assign push_n.y = flip_reg ? -best_n.y : best_n.y;

    // per-axis interval test
    assign h_min     = (hia_reg < hib_reg) ? hia_reg : hib_reg;
    assign l_max     = (loa_reg > lob_reg) ? loa_reg : lob_reg;
    assign d_val     = h_min - l_max;
    assign separated = (loa_reg > hib_reg) || (lob_reg > hia_reg);

    // rounding of accumulator results
    assign rnd31  = (acc + (ACC_W'(1) <<< 30)) >>> 31;
    assign rnd30  = (acc + (ACC_W'(1) <<< 29)) >>> 30;
    assign vsum   = ACC_W'(rect ? (step_reg[0] ? by_reg : bx_reg)
                                : (step_reg[0] ? ay_reg : ax_reg)) + rnd31;
    assign cval   = step_reg[0] ? ay_reg : ax_reg;
    assign msum   = ACC_W'(cval) - rnd30;
    assign mclamp = (msum > ACC_W'(signed'({1'b0, {(CTR_W-1){1'b1}}}))) ?
                        {1'b0, {(CTR_W-1){1'b1}}} :
                    (msum < ACC_W'(signed'({1'b1, {(CTR_W-1){1'b0}}}))) ?
                        {1'b1, {(CTR_W-1){1'b0}}} : msum[CTR_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_TRIG;
                    step_next  = '0;
                    phase_next = '0;
                end
            end
            ST_TRIG:
            begin
                if (phase_reg == 2'd0)
                    phase_next = 2'd1;
                else if (cordic_done)
                begin
                    phase_next = 2'd0;
                    if (step_reg[0])
                    begin
                        state_next = ST_CORNER;
                        step_next  = '0;
                    end
                    else
                        step_next = 6'd1;
                end
            end
            ST_CORNER:
            begin
                if (phase_reg != 2'd2)
                    phase_next = phase_reg + 2'd1;
                else
                begin
                    phase_next = 2'd0;
                    if (step_reg[3:0] == 4'd15)
                    begin
                        state_next = ST_PROJ;
                        step_next  = '0;
                    end
                    else
                        step_next = step_reg + 6'd1;
                end
            end
            ST_PROJ:
            begin
                if (phase_reg != 2'd2)
                    phase_next = phase_reg + 2'd1;
                else
                begin
                    phase_next = 2'd0;
                    if (step_reg[2:0] == 3'd7)
                        state_next = ST_AXIS;
                    else
                        step_next = step_reg + 6'd1;
                end
            end
            ST_AXIS:
            begin
                if (separated)
                    state_next = ST_DONE;
                else if (step_reg[5:3] == 3'd7)
                begin
                    state_next = ST_ORIENT;
                    step_next  = '0;
                end
                else
                begin
                    state_next = ST_PROJ;
                    step_next  = step_reg + 6'd1;
                end
            end
            ST_ORIENT:
            begin
                if (phase_reg != 2'd2)
                    phase_next = phase_reg + 2'd1;
                else
                begin
                    phase_next = 2'd0;
                    state_next = ST_PUSH;
                    step_next  = '0;
                end
            end
            ST_PUSH:
            begin
                if (phase_reg != 2'd2)
                    phase_next = phase_reg + 2'd1;
                else
                begin
                    phase_next = 2'd0;
                    if (step_reg[0])
                        state_next = ST_DONE;
                    else
                        step_next = 6'd1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        cordic_start  = (state_reg == ST_TRIG) && (phase_reg == 2'd0);
        mac_en        = 1'b0;
        mac_op.clr    = (phase_reg == 2'd0);
        mac_op.neg    = 1'b0;
        mac_op.a      = '0;
        mac_op.b      = '0;
        unique case (state_reg)
            ST_CORNER:
            begin
                mac_en = (phase_reg != 2'd2);
                if (phase_reg == 2'd0)
                begin
                    mac_op.a   = len_w;
                    mac_op.b   = step_reg[0] ? rs : rc;
                    mac_op.neg = sx_neg;
                end
                else
                begin
                    mac_op.a   = len_h;
                    mac_op.b   = step_reg[0] ? rc : rs;
                    mac_op.neg = step_reg[0] ? sy_neg : !sy_neg;
                end
            end
            ST_PROJ:
            begin
                mac_en   = (phase_reg != 2'd2);
                mac_op.a = (phase_reg == 2'd0) ? OPD_W'(vx_reg[vi]) : OPD_W'(vy_reg[vi]);
                mac_op.b = (phase_reg == 2'd0) ? proj_n.x : proj_n.y;
            end
            ST_ORIENT:
            begin
                mac_en   = (phase_reg != 2'd2);
                mac_op.a = (phase_reg == 2'd0) ? best_n.x : best_n.y;
                mac_op.b = (phase_reg == 2'd0) ? OPD_W'(ACC_W'(bx_reg) - ACC_W'(ax_reg))
                                               : OPD_W'(ACC_W'(by_reg) - ACC_W'(ay_reg));
            end
            ST_PUSH:
            begin
                mac_en   = (phase_reg != 2'd2);
                mac_op.a = (phase_reg == 2'd0) ? OPD_W'(depth_reg) : '0;
                mac_op.b = step_reg[0] ? push_n.y : push_n.x;
            end
            default:
                mac_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            phase_reg <= phase_next;
            if ((state_reg == ST_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_reg <= s_axis_tdata[23:0];
            ay_reg <= s_axis_tdata[47:24];
            aw_reg <= s_axis_tdata[70:48];
            ah_reg <= s_axis_tdata[93:71];
            at_reg <= s_axis_tdata[109:94];
            bx_reg <= s_axis_tdata[133:110];
            by_reg <= s_axis_tdata[157:134];
            bw_reg <= s_axis_tdata[180:158];
            bh_reg <= s_axis_tdata[203:181];
            bt_reg <= s_axis_tdata[219:204];
        end
        if ((state_reg == ST_TRIG) && (phase_reg != 2'd0) && cordic_done)
        begin
            if (step_reg[0])
            begin
                b_cos_reg <= cordic_cos;
                b_sin_reg <= cordic_sin;
            end
            else
            begin
                a_cos_reg <= cordic_cos;
                a_sin_reg <= cordic_sin;
            end
        end
        if ((state_reg == ST_CORNER) && (phase_reg == 2'd2))
        begin
            if (step_reg[0])
                vy_reg[{rect, corner}] <= vsum[VTX_W-1:0];
            else
                vx_reg[{rect, corner}] <= vsum[VTX_W-1:0];
        end
        if ((state_reg == ST_PROJ) && (phase_reg == 2'd2))
        begin
            if (!vi[2])
            begin
                if ((vi[1:0] == 2'd0) || (acc < loa_reg))
                    loa_reg <= acc;
                if ((vi[1:0] == 2'd0) || (acc > hia_reg))
                    hia_reg <= acc;
            end
            else
            begin
                if ((vi[1:0] == 2'd0) || (acc < lob_reg))
                    lob_reg <= acc;
                if ((vi[1:0] == 2'd0) || (acc > hib_reg))
                    hib_reg <= acc;
            end
        end
        if (state_reg == ST_AXIS)
        begin
            if (separated)
            begin
                found_reg <= 1'b0;
                depth_reg <= '0;
                mx_reg    <= ax_reg;
                my_reg    <= ay_reg;
            end
            else if ((step_reg[5:3] == 3'd0) || (d_val < best_reg))
            begin
                best_reg     <= d_val;
                best_idx_reg <= step_reg[5:3];
            end
        end
        if ((state_reg == ST_ORIENT) && (phase_reg == 2'd2))
        begin
            found_reg <= 1'b1;
            flip_reg  <= acc[ACC_W-1] || (acc == '0);
            if (((best_reg + (ACC_W'(1) <<< 29)) >>> 30) > ACC_W'(DEPTH_MAX))
                depth_reg <= DEPTH_MAX;
            else
                depth_reg <= LEN_W'((best_reg + (ACC_W'(1) <<< 29)) >>> 30);
        end
        if ((state_reg == ST_PUSH) && (phase_reg == 2'd2))
        begin
            if (step_reg[0])
                my_reg <= mclamp;
            else
                mx_reg <= mclamp;
        end
        if ((state_reg == ST_DONE) && out_free)
            out_data_reg <= {my_reg, mx_reg, depth_reg, found_reg};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

>>> rtl/core/obb_sat_checker.sv
// Port-level checks for the oriented box overlap unit, bound to the top level.
module obb_sat_checker
    import obb_sat_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("result valid during reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready straight after input transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> (m_axis_tdata[23:1] == '0))
        else $error("nonzero depth without overlap");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |-> !$past(s_axis_tvalid && s_axis_tready))
        else $error("input transfers on consecutive cycles");

endmodule

bind obb_separating_axis_collision_unit obb_sat_checker u_obb_sat_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
